FILE: src/prba_pkg.sv
`timescale 1ns / 1ps
// Package for the pixel rotate and bin accumulate block.
// Holds the size constants, field widths, register indexes and reset values.
// Depends on nothing.
package prba_pkg;

    // Largest source image and the sample width.
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 512;
    localparam int PIXEL_BITS  = 16;

    // Counter and coordinate widths follow from the maximum sizes.
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ADDR_W = ROW_W + COL_W;

    // Field widths fixed by the interface.
    localparam int FRAME_COLUMNS_W = 11;
    localparam int FRAME_ROWS_W    = 10;
    localparam int PIX_W           = 16;
    localparam int BIN_X_W         = 9;
    localparam int BIN_Y_W         = 10;
    localparam int SUM_W           = 18;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = FRAME_COLUMNS_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_COLUMNS     = 3'd0,
        CFG_FRAME_ROWS        = 3'd1,
        CFG_BIN_BY_TWO        = 3'd2,
        CFG_WIDE_PIXELS       = 3'd3,
        CFG_SUBTRACT_PEDESTAL = 3'd4
    } cfg_index_t;

    // Register values after reset.
    localparam logic [FRAME_COLUMNS_W-1:0] FRAME_COLUMNS_RESET = 11'd640;
    localparam logic [FRAME_ROWS_W-1:0]    FRAME_ROWS_RESET    = 10'd480;

endpackage

FILE: src/pixel_rotate_bin_accumulate.sv
`timescale 1ns / 1ps
// A pixel moves from the address stage into the read-modify-write stage register,
// then the output register, which presents its result until it transfers. Throughput:
// one pixel per cycle unless the output stalls, at most one bin-store read and one write
// each cycle; a pixel whose bin is written at its own transfer edge takes the sum by
// forwarding. Reset: configuration defaults, counters at zero, pipeline empty; the bin
// store is not cleared, as each bin restarts on its first pixel. Depends on prba_pkg.
module pixel_rotate_bin_accumulate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_write,
    input  logic [prba_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [prba_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Pixel input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [prba_pkg::PIX_W-1:0]            pixel_value,
    input  logic [prba_pkg::PIX_W-1:0]            pedestal,
    input  logic                                  frame_start,
    // Bin result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [prba_pkg::BIN_X_W-1:0]          bin_x,
    output logic [prba_pkg::BIN_Y_W-1:0]          bin_y,
    output logic [prba_pkg::SUM_W-1:0]            bin_sum,
    output logic                                  dropped,
    output logic                                  frame_done
);

    import prba_pkg::*;

    // Configuration registers.
    logic [FRAME_COLUMNS_W-1:0] frame_columns_reg;
    logic [FRAME_ROWS_W-1:0]    frame_rows_reg;
    logic                       bin_by_two_reg;
    logic                       wide_pixels_reg;
    logic                       subtract_pedestal_reg;

    // Raster counters.
    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    // Bin store and its registered read data.
    logic [SUM_W-1:0] bin_store [2**ADDR_W];
    logic [SUM_W-1:0] rd_data_reg;

    // Read-modify-write stage.
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_first_reg;
    logic              s1_drop_reg;
    logic              s1_done_reg;
    logic              s1_fwd_reg;
    logic [SUM_W-1:0]  s1_fwd_data_reg;

    // Output register.
    logic               out_valid_reg;
    logic [BIN_X_W-1:0] bin_x_reg;
    logic [BIN_Y_W-1:0] bin_y_reg;
    logic [SUM_W-1:0]   bin_sum_reg;
    logic               dropped_reg;
    logic               frame_done_reg;

    // Handshake.
    logic in_accept;
    logic s1_advance;
    logic out_free;

    // Address stage signals.
    logic [FRAME_COLUMNS_W-1:0] cols;
    logic [FRAME_ROWS_W-1:0]    rows;
    logic [COL_W-1:0]           col_cur;
    logic [ROW_W-1:0]           row_cur;
    logic [PIX_W-1:0]           pmask;
    logic [PIX_W-1:0]           pix_m;
    logic [PIX_W-1:0]           ped_m;
    logic [PIX_W-1:0]           pix_next;
    logic [FRAME_ROWS_W-1:0]    bins_x;
    logic [FRAME_COLUMNS_W-1:0] bins_y;
    logic [ROW_W-1:0]           brow;
    logic [COL_W-1:0]           bcol;
    logic                       drop_next;
    logic                       first_next;
    logic                       done_next;
    logic [FRAME_ROWS_W-1:0]    bx_full;
    logic [ADDR_W-1:0]          addr_next;
    logic [COL_W:0]             col_inc;
    logic [ROW_W:0]             row_inc;
    logic                       fwd_next;

    // Modify stage signals.
    logic [SUM_W-1:0] operand;
    logic [SUM_W-1:0] sum_next;

    // Handshake: the output register frees the stage behind it whenever it empties
    // or its transfer completes.
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_columns_reg     <= FRAME_COLUMNS_RESET;
            frame_rows_reg        <= FRAME_ROWS_RESET;
            bin_by_two_reg        <= 1'b0;
            wide_pixels_reg       <= 1'b1;
            subtract_pedestal_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_COLUMNS:     frame_columns_reg     <= cfg_data;
                CFG_FRAME_ROWS:        frame_rows_reg        <= cfg_data[FRAME_ROWS_W-1:0];
                CFG_BIN_BY_TWO:        bin_by_two_reg        <= cfg_data[0];
                CFG_WIDE_PIXELS:       wide_pixels_reg       <= cfg_data[0];
                CFG_SUBTRACT_PEDESTAL: subtract_pedestal_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Effective sizes, clamped to the supported range.
    always_comb
    begin
        if (frame_columns_reg == '0)
            cols = FRAME_COLUMNS_W'(1);
        else if (frame_columns_reg > FRAME_COLUMNS_W'(MAX_COLUMNS))
            cols = FRAME_COLUMNS_W'(MAX_COLUMNS);
        else
            cols = frame_columns_reg;

        if (frame_rows_reg == '0)
            rows = FRAME_ROWS_W'(1);
        else if (frame_rows_reg > FRAME_ROWS_W'(MAX_ROWS))
            rows = FRAME_ROWS_W'(MAX_ROWS);
        else
            rows = frame_rows_reg;
    end

    // Address stage: position, pedestal, bin coordinates and next counters.
    always_comb
    begin
        col_cur = frame_start ? '0 : column_count_reg;
        row_cur = frame_start ? '0 : row_count_reg;
        if (FRAME_COLUMNS_W'(col_cur) >= cols)
            col_cur = '0;
        if (FRAME_ROWS_W'(row_cur) >= rows)
            row_cur = '0;

        pmask    = wide_pixels_reg ? PIX_W'((32'd1 << PIXEL_BITS) - 32'd1) : PIX_W'(8'hFF);
        pix_m    = pixel_value & pmask;
        ped_m    = pedestal & pmask;
        pix_next = subtract_pedestal_reg ? ((pix_m - ped_m) & pmask) : pix_m;

        bins_x = bin_by_two_reg ? (rows >> 1) : rows;
        bins_y = bin_by_two_reg ? (cols >> 1) : cols;
        brow   = bin_by_two_reg ? (row_cur >> 1) : row_cur;
        bcol   = bin_by_two_reg ? (col_cur >> 1) : col_cur;

        drop_next  = (FRAME_ROWS_W'(brow) >= bins_x) || (FRAME_COLUMNS_W'(bcol) >= bins_y);
        first_next = !bin_by_two_reg || !(row_cur[0] | col_cur[0]);
        bx_full    = bins_x - FRAME_ROWS_W'(1) - FRAME_ROWS_W'(brow);
        addr_next  = {bx_full[ROW_W-1:0], bcol};

        done_next = (FRAME_ROWS_W'(row_cur) == rows - FRAME_ROWS_W'(1))
                 && (FRAME_COLUMNS_W'(col_cur) == cols - FRAME_COLUMNS_W'(1));

        // Raster advance with wrap at the end of a row and of the frame.
        col_inc           = {1'b0, col_cur} + 1'b1;
        row_inc           = {1'b0, row_cur} + 1'b1;
        column_count_next = col_inc[COL_W-1:0];
        row_count_next    = row_cur;
        if (FRAME_COLUMNS_W'(col_inc) >= cols)
        begin
            column_count_next = '0;
            row_count_next    = row_inc[ROW_W-1:0];
            if (FRAME_ROWS_W'(row_inc) >= rows)
                row_count_next = '0;
        end

        // The store read at this edge misses a write to the same bin at this edge.
        fwd_next = s1_advance && !s1_drop_reg && (s1_addr_reg == addr_next);
    end

    // Modify stage: the bin restarts on its first pixel, otherwise accumulates.
    always_comb
    begin
        operand  = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
        sum_next = (s1_first_reg ? '0 : operand) + SUM_W'(s1_pix_reg);
    end

    // Counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (in_accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // Bin store: read on pixel transfer, write back when the stage moves on unless the pixel is dropped.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            rd_data_reg <= bin_store[addr_next];
        if (s1_advance && !s1_drop_reg)
            bin_store[s1_addr_reg] <= sum_next;
    end

    // Read-modify-write stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    // Read-modify-write stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg     <= addr_next;
            s1_pix_reg      <= pix_next;
            s1_first_reg    <= first_next;
            s1_drop_reg     <= drop_next;
            s1_done_reg     <= done_next;
            s1_fwd_reg      <= fwd_next;
            s1_fwd_data_reg <= sum_next;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output register payload; a dropped pixel reports zero coordinates and sum.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            bin_x_reg      <= s1_drop_reg ? '0 : s1_addr_reg[ADDR_W-1:COL_W];
            bin_y_reg      <= s1_drop_reg ? '0 : s1_addr_reg[COL_W-1:0];
            bin_sum_reg    <= s1_drop_reg ? '0 : sum_next;
            dropped_reg    <= s1_drop_reg;
            frame_done_reg <= s1_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_x      = bin_x_reg;
    assign bin_y      = bin_y_reg;
    assign bin_sum    = bin_sum_reg;
    assign dropped    = dropped_reg;
    assign frame_done = frame_done_reg;

    // The input is held back only by a full stage behind a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline can move");

    // Forwarding is only taken for a pixel transferred at the same edge as a store write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fwd_next) |-> s1_advance && !s1_drop_reg)
        else $error("forwarding without a store write in the same cycle");

    // A dropped pixel carries no bin position and no sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (bin_x == '0 && bin_y == '0 && bin_sum == '0))
        else $error("dropped result with non-zero bin fields");

    // A result that appears on an idle output is preceded by a pixel passing the modify stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_advance))
        else $error("result appeared without a pixel leaving the modify stage");

endmodule

FILE: sim/bin_result_checker.sv
`timescale 1ns / 1ps
// Checker for the pixel rotate and bin accumulate block: watches the configuration port
// and both channels, predicts every bin result and compares it field by field.
// Depends on prba_pkg.
module bin_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [prba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [prba_pkg::PIX_W-1:0]          pixel_value,
    input  logic [prba_pkg::PIX_W-1:0]          pedestal,
    input  logic                                frame_start,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [prba_pkg::BIN_X_W-1:0]        bin_x,
    input  logic [prba_pkg::BIN_Y_W-1:0]        bin_y,
    input  logic [prba_pkg::SUM_W-1:0]          bin_sum,
    input  logic                                dropped,
    input  logic                                frame_done,
    output int                                  fail_count,
    output int                                  pending
);

    import prba_pkg::*;

    typedef struct packed {
        logic [BIN_X_W-1:0] bin_x;
        logic [BIN_Y_W-1:0] bin_y;
        logic [SUM_W-1:0]   bin_sum;
        logic               dropped;
        logic               frame_done;
    } bin_result_t;

    // Shadow copy of the configuration registers.
    logic [FRAME_COLUMNS_W-1:0] cfg_columns;
    logic [FRAME_ROWS_W-1:0]    cfg_rows;
    logic                       cfg_binned;
    logic                       cfg_wide;
    logic                       cfg_subtract;

    // Raster position of the next pixel and the running bin totals.
    int                         row_pos;
    int                         col_pos;
    logic [SUM_W-1:0]           bin_totals [int];

    bin_result_t                expected_bins [$];
    bin_result_t                oldest;

    // Works out the result of one pixel and updates the raster position and bin totals.
    function automatic bin_result_t rotate_and_bin(input logic [PIX_W-1:0] raw,
                                                   input logic [PIX_W-1:0] raw_pedestal,
                                                   input logic restart);
        int               cols;
        int               rows;
        int               bins_x;
        int               bins_y;
        int               brow;
        int               bcol;
        int               addr;
        logic [PIX_W-1:0] mask;
        logic [PIX_W-1:0] sample;
        logic             opens_bin;
        bin_result_t      r;

        // Size registers out of range are clamped to 1..maximum.
        cols = (cfg_columns == 0) ? 1 : ((cfg_columns > MAX_COLUMNS) ? MAX_COLUMNS
                                                                       : int'(cfg_columns));
        rows = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows));
        r = '0;

        // A new frame restarts the counters, and so does a size that shrank under them.
        if (restart)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= rows) row_pos = 0;

        mask = cfg_wide ? {PIX_W{1'b1}} : PIX_W'(8'hFF);
        sample = raw & mask;
        if (cfg_subtract) sample = (sample - (raw_pedestal & mask)) & mask;

        bins_x = cfg_binned ? rows / 2 : rows;
        bins_y = cfg_binned ? cols / 2 : cols;
        brow = cfg_binned ? row_pos / 2 : row_pos;
        bcol = cfg_binned ? col_pos / 2 : col_pos;

        if (brow >= bins_x || bcol >= bins_y)
        begin
            // Odd last row or column with binning: the pixel is discarded.
            r.dropped = 1'b1;
        end
        else
        begin
            // The top-left pixel of a bin starts its sum afresh.
            opens_bin = !cfg_binned || (((row_pos | col_pos) & 1) == 0);
            r.bin_x = BIN_X_W'(bins_x - 1 - brow);
            r.bin_y = BIN_Y_W'(bcol);
            addr = (bins_x - 1 - brow) * MAX_COLUMNS + bcol;
            if (opens_bin || !bin_totals.exists(addr)) r.bin_sum = SUM_W'(sample);
            else r.bin_sum = bin_totals[addr] + SUM_W'(sample);
            bin_totals[addr] = r.bin_sum;
        end

        r.frame_done = (row_pos == rows - 1) && (col_pos == cols - 1);

        col_pos++;
        if (col_pos >= cols)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Configuration writes, pixel transfers and result transfers, all sampled at the edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_columns = FRAME_COLUMNS_RESET;
            cfg_rows = FRAME_ROWS_RESET;
            cfg_binned = 1'b0;
            cfg_wide = 1'b1;
            cfg_subtract = 1'b0;
            row_pos = 0;
            col_pos = 0;
            expected_bins.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_COLUMNS:     cfg_columns = cfg_data[FRAME_COLUMNS_W-1:0];
                    CFG_FRAME_ROWS:        cfg_rows = cfg_data[FRAME_ROWS_W-1:0];
                    CFG_BIN_BY_TWO:        cfg_binned = cfg_data[0];
                    CFG_WIDE_PIXELS:       cfg_wide = cfg_data[0];
                    CFG_SUBTRACT_PEDESTAL: cfg_subtract = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_bins = {expected_bins,
                                 rotate_and_bin(pixel_value, pedestal, frame_start)};

            if (out_valid && !out_stall)
            begin
                if (expected_bins.size() == 0)
                begin
                    $display("%0t: unexpected bin result, expected none, %s%0d y=%0d sum=%0d",
                             $time, "actual x=", bin_x, bin_y, bin_sum);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_bins.pop_front();
                    check_field("bin_x", oldest.bin_x, bin_x);
                    check_field("bin_y", oldest.bin_y, bin_y);
                    check_field("bin_sum", oldest.bin_sum, bin_sum);
                    check_field("dropped", oldest.dropped, dropped);
                    check_field("frame_done", oldest.frame_done, frame_done);
                end
            end
            pending = expected_bins.size();
        end
    end

endmodule

FILE: sim/pixel_rotate_bin_accumulate_test.sv
`timescale 1ns / 1ps
// Testbench top for the pixel rotate and bin accumulate block: drives configuration,
// pixel frames and result back-pressure, and gives the verdict.
// Depends on prba_pkg, pixel_rotate_bin_accumulate and bin_result_checker.
module pixel_rotate_bin_accumulate_test;
    import prba_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PIXELS = 1950;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIX_W-1:0]       pixel_value = '0;
    logic [PIX_W-1:0]       pedestal = '0;
    logic                   frame_start = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BIN_X_W-1:0]     bin_x;
    logic [BIN_Y_W-1:0]     bin_y;
    logic [SUM_W-1:0]       bin_sum;
    logic                   dropped;
    logic                   frame_done;
    int                     fail_count;
    int                     pending;
    int                     calm_left = 0;

    pixel_rotate_bin_accumulate dut (.*);

    bin_result_checker result_check (.*);

    always #10 clk = ~clk;

    // Idle lengths: mostly none or short, a few long, with calm stretches now and then.
    function automatic int draw_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) calm_left = $urandom_range(20, 120);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] draw_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom_range(0, 65535));
    endfunction

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One pixel transfer; valid stays high afterwards so that the next pixel can follow.
    task automatic send_pixel(input logic [PIX_W-1:0] sample, input logic [PIX_W-1:0] base,
                              input logic restart);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_value <= sample;
        pedestal <= base;
        frame_start <= restart;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Random back-pressure on the result channel.
    initial
    begin : result_backpressure
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                hold = draw_gap();
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int burst;
        int pos;
        int frame_len;
        int cols_reg;
        int rows_reg;
        int r;
        logic restart;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: 640 by 480, no binning, 16-bit pixels, pedestal ignored.
        send_pixel(16'hFFFF, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 1'b0);
        drain();

        // Oversized registers clamp to the maximum; 8-bit pixels with pedestal wrap.
        write_reg(CFG_FRAME_COLUMNS, 2047);
        write_reg(CFG_FRAME_ROWS, 1023);
        write_reg(CFG_WIDE_PIXELS, 0);
        write_reg(CFG_SUBTRACT_PEDESTAL, 1);
        send_pixel(16'h1234, 16'h0056, 1'b1);
        send_pixel(16'hAB00, 16'h00FF, 1'b0);
        send_pixel(16'h00FF, 16'hFF00, 1'b0);
        drain();

        // Zero sizes act as a one-pixel frame, so every pixel ends a frame.
        write_reg(CFG_FRAME_COLUMNS, 0);
        write_reg(CFG_FRAME_ROWS, 0);
        write_reg(CFG_WIDE_PIXELS, 1);
        send_pixel(16'h0000, 16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 1'b0);
        drain();

        // Odd 3 by 3 frame with binning: the last row and column are dropped.
        write_reg(CFG_FRAME_COLUMNS, 3);
        write_reg(CFG_FRAME_ROWS, 3);
        write_reg(CFG_BIN_BY_TWO, 1);
        write_reg(CFG_SUBTRACT_PEDESTAL, 0);
        for (int k = 0; k < 9; k++) send_pixel(16'hFFFF, 16'h0000, k == 0);
        drain();

        // Sizes shrink in mid-frame, so both counters fall back to zero.
        write_reg(CFG_FRAME_COLUMNS, 5);
        write_reg(CFG_FRAME_ROWS, 4);
        write_reg(CFG_BIN_BY_TWO, 0);
        for (int k = 0; k < 8; k++) send_pixel(draw_sample(), draw_sample(), k == 0);
        drain();
        write_reg(CFG_FRAME_COLUMNS, 2);
        write_reg(CFG_FRAME_ROWS, 1);
        send_pixel(draw_sample(), draw_sample(), 1'b0);
        send_pixel(draw_sample(), draw_sample(), 1'b0);
        drain();

        // Random phases: a fresh setting, then whole frames with now and then an early restart.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            r = $urandom_range(0, 19);
            case (r)
                0: cols_reg = 0;
                1: cols_reg = 1;
                2: cols_reg = MAX_COLUMNS;
                3: cols_reg = $urandom_range(MAX_COLUMNS + 1, 2047);
                4: cols_reg = 2047;
                default: cols_reg = $urandom_range(1, 12);
            endcase
            r = $urandom_range(0, 19);
            case (r)
                0: rows_reg = 0;
                1: rows_reg = 1;
                2: rows_reg = MAX_ROWS;
                3: rows_reg = $urandom_range(MAX_ROWS + 1, 1023);
                4: rows_reg = 1023;
                default: rows_reg = $urandom_range(1, 10);
            endcase
            write_reg(CFG_FRAME_COLUMNS, cols_reg);
            write_reg(CFG_FRAME_ROWS, rows_reg);
            write_reg(CFG_BIN_BY_TWO, $urandom_range(0, 1));
            write_reg(CFG_WIDE_PIXELS, $urandom_range(0, 1));
            write_reg(CFG_SUBTRACT_PEDESTAL, $urandom_range(0, 1));

            if (cols_reg == 0) cols_reg = 1;
            if (cols_reg > MAX_COLUMNS) cols_reg = MAX_COLUMNS;
            if (rows_reg == 0) rows_reg = 1;
            if (rows_reg > MAX_ROWS) rows_reg = MAX_ROWS;
            frame_len = cols_reg * rows_reg;
            if (frame_len <= 40) burst = frame_len * $urandom_range(1, 4) + $urandom_range(0, 3);
            else burst = $urandom_range(20, 80);

            // Each phase opens with a frame start so that no bin is read before it is written.
            pos = 0;
            for (int k = 0; k < burst; k++)
            begin
                if (k == 0) restart = 1'b1;
                else if (pos == 0) restart = 1'($urandom_range(0, 1));
                else restart = ($urandom_range(0, 39) == 0);
                if (restart) pos = 0;
                pos++;
                if (pos >= frame_len) pos = 0;
                send_pixel(draw_sample(), draw_sample(), restart);
            end
            sent += burst;
            drain();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
src/prba_pkg.sv
src/pixel_rotate_bin_accumulate.sv
sim/bin_result_checker.sv
sim/pixel_rotate_bin_accumulate_test.sv
